@@ rtl/sled_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sled_pkg;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_BASE  = 2'd1;
	localparam logic [1:0] ACT_EVENT = 2'd2;

	localparam logic [1:0] MODE_OFF     = 2'd0;
	localparam logic [1:0] MODE_SOLID   = 2'd1;
	localparam logic [1:0] MODE_BREATHE = 2'd2;
	localparam logic [1:0] MODE_BLINK   = 2'd3;

	localparam int NUM_REGS   = 6;
	localparam int NUM_SIGS   = 23;
	localparam logic [7:0] FULL_LEVEL = 8'd255;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  pal;
		logic [11:0] period;
		logic [6:0]  on_ms;
		logic [6:0]  gap;
		logic [1:0]  flashes;
		logic [10:0] dur;
		logic [7:0]  minlvl;
	} pat_t;

	typedef struct packed {
		logic       start;
		logic [1:0] action;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic emit;
	} sts_t;

	function automatic pat_t pattern_of(input logic [4:0] sig);
		pat_t p;
		p = '0;
		unique case (sig)
			5'd1:  p = '{MODE_BREATHE, 4'd0, 12'd2200, 7'd0, 7'd0, 2'd0, 11'd0, 8'd48};
			5'd2:  p = '{MODE_SOLID, 4'd1, 12'd0, 7'd0, 7'd0, 2'd0, 11'd0, 8'd0};
			5'd3:  p = '{MODE_BREATHE, 4'd2, 12'd1800, 7'd0, 7'd0, 2'd0, 11'd0, 8'd40};
			5'd4:  p = '{MODE_BREATHE, 4'd3, 12'd2200, 7'd0, 7'd0, 2'd0, 11'd0, 8'd40};
			5'd5:  p = '{MODE_SOLID, 4'd4, 12'd0, 7'd0, 7'd0, 2'd0, 11'd0, 8'd0};
			5'd6:  p = '{MODE_SOLID, 4'd5, 12'd0, 7'd0, 7'd0, 2'd0, 11'd0, 8'd0};
			5'd7:  p = '{MODE_SOLID, 4'd6, 12'd0, 7'd0, 7'd0, 2'd0, 11'd0, 8'd0};
			5'd8:  p = '{MODE_BREATHE, 4'd7, 12'd1300, 7'd0, 7'd0, 2'd0, 11'd0, 8'd48};
			5'd9:  p = '{MODE_BLINK, 4'd4, 12'd700, 7'd80, 7'd100, 2'd3, 11'd900, 8'd0};
			5'd10: p = '{MODE_BLINK, 4'd8, 12'd700, 7'd100, 7'd120, 2'd3, 11'd1400, 8'd0};
			5'd11: p = '{MODE_SOLID, 4'd8, 12'd0, 7'd0, 7'd0, 2'd0, 11'd0, 8'd0};
			5'd12: p = '{MODE_BLINK, 4'd9, 12'd650, 7'd90, 7'd120, 2'd2, 11'd850, 8'd0};
			5'd13: p = '{MODE_SOLID, 4'd9, 12'd0, 7'd0, 7'd0, 2'd0, 11'd0, 8'd0};
			5'd14: p = '{MODE_SOLID, 4'd5, 12'd0, 7'd0, 7'd0, 2'd0, 11'd0, 8'd0};
			5'd15: p = '{MODE_SOLID, 4'd10, 12'd0, 7'd0, 7'd0, 2'd0, 11'd0, 8'd0};
			5'd16: p = '{MODE_BLINK, 4'd11, 12'd1000, 7'd120, 7'd0, 2'd1, 11'd600, 8'd0};
			5'd17: p = '{MODE_SOLID, 4'd5, 12'd0, 7'd0, 7'd0, 2'd0, 11'd0, 8'd0};
			5'd18: p = '{MODE_SOLID, 4'd10, 12'd0, 7'd0, 7'd0, 2'd0, 11'd0, 8'd0};
			5'd19: p = '{MODE_BLINK, 4'd11, 12'd1000, 7'd80, 7'd0, 2'd1, 11'd500, 8'd0};
			5'd20: p = '{MODE_BLINK, 4'd11, 12'd1000, 7'd30, 7'd0, 2'd1, 11'd150, 8'd0};
			5'd21: p = '{MODE_BLINK, 4'd4, 12'd1000, 7'd60, 7'd0, 2'd1, 11'd500, 8'd0};
			5'd22: p = '{MODE_BLINK, 4'd8, 12'd800, 7'd80, 7'd120, 2'd3, 11'd1400, 8'd0};
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

@@ rtl/sled_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sled_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	output logic             out_valid,
	input  wire logic        out_ready,
	output sled_pkg::cmd_t   cmd,
	input  wire sled_pkg::sts_t sts
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0] state_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = (state_q == ST_OUT);
	assign cmd.start  = in_valid && in_ready;
	assign cmd.action = action;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (cmd.start) state_q <= ST_BUSY;
				ST_BUSY: if (sts.done) state_q <= sts.emit ? ST_OUT : ST_IDLE;
				ST_OUT:  if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/sled_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sled_dp (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sled_pkg::cmd_t cmd,
	output sled_pkg::sts_t   sts,
	input  wire logic [31:0] now_ms,
	input  wire logic [4:0]  sig,
	input  wire logic        cfg_valid,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_data,
	output logic [23:0]      color
);

	// steps of one tick
	localparam logic [3:0] P_IDLE  = 4'd0;
	localparam logic [3:0] P_SEL   = 4'd1;
	localparam logic [3:0] P_MOD   = 4'd2;
	localparam logic [3:0] P_LVL   = 4'd3;
	localparam logic [3:0] P_LDIV  = 4'd4;
	localparam logic [3:0] P_SCL   = 4'd5;
	localparam logic [3:0] P_FIN   = 4'd7;

	logic [47:0] regs_q [sled_pkg::NUM_REGS];
	logic [4:0]  base_q, evt_q;
	logic [31:0] evt_start_q, t_q;
	logic [23:0] shown_q;
	logic [3:0]  ph_q;
	logic        done_q, emit_q;
	sled_pkg::pat_t pat_q;
	logic [23:0] pal_q, next_q;
	logic [1:0]  chan_q;

	// shared restoring divider: 32-bit dividend, 12-bit divisor, one bit per cycle
	logic [31:0] dvd_q;
	logic [11:0] rem_q;
	logic [11:0] dvs_q;
	logic [5:0]  dcnt_q;
	logic [12:0] rtry;
	logic [13:0] rsub;

	logic [11:0] cyc_q;
	logic [7:0]  lvl_q;

	sled_pkg::pat_t  ev_pat;
	logic [31:0]     el;
	logic [11:0]     half;
	logic [11:0]     ramp;
	logic [7:0]      span;
	logic [19:0]     lvl_num;
	logic [23:0]     palc;
	logic [3:0]      pidx;
	logic [2:0]      ridx;
	logic [7:0]      chv;
	logic [15:0]     prod;
	logic [16:0]     prod_p1;
	logic [16:0]     dsum;
	logic [7:0]      chq;
	logic            blink_on;
	logic [8:0]      st1, st2;

	assign ev_pat = sled_pkg::pattern_of(evt_q);
	assign el     = now_ms - evt_start_q;
	assign half   = pat_q.period >> 1;
	assign ramp   = (cyc_q < half) ? cyc_q : (pat_q.period - cyc_q);
	assign span   = sled_pkg::FULL_LEVEL - pat_q.minlvl;
	assign lvl_num = span * ramp;
	assign pidx   = pat_q.pal;
	assign ridx   = pidx[3:1];
	assign palc   = pidx[0] ? regs_q[ridx][47:24] : regs_q[ridx][23:0];
	assign rtry   = {rem_q, dvd_q[31]};
	assign rsub   = {1'b0, rtry} - {2'b0, dvs_q};
	assign sts.done = done_q;
	assign sts.emit = emit_q;
	assign color    = shown_q;

	always_comb begin
		unique case (chan_q)
			2'd0:    chv = pal_q[23:16];
			2'd1:    chv = pal_q[15:8];
			default: chv = pal_q[7:0];
		endcase
	end
	assign prod = chv * lvl_q;

	// x/255 for x up to 65534: ((x+1) + ((x+1) >> 8)) >> 8
	assign prod_p1 = {1'b0, prod} + 17'd1;
	assign dsum    = prod_p1 + {8'b0, prod_p1[16:8]};
	assign chq     = dsum[15:8];

	// flash windows; cyc below period fits in 12 bits
	assign st1 = {2'b0, pat_q.on_ms} + {2'b0, pat_q.gap};
	assign st2 = {st1[7:0], 1'b0};
	always_comb begin
		blink_on = (cyc_q < {5'b0, pat_q.on_ms});
		if (pat_q.flashes >= 2'd2 && cyc_q >= {3'b0, st1}
			&& cyc_q < {3'b0, st1} + {5'b0, pat_q.on_ms}) blink_on = 1'b1;
		if (pat_q.flashes == 2'd3 && cyc_q >= {3'b0, st2}
			&& cyc_q < {3'b0, st2} + {5'b0, pat_q.on_ms}) blink_on = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sled_pkg::NUM_REGS; i++)
				regs_q[i] <= '0;
		end else if (cfg_valid && cfg_index < 3'(sled_pkg::NUM_REGS)) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= 5'd1;
			evt_q       <= '0;
			evt_start_q <= '0;
			shown_q     <= '0;
			ph_q        <= P_IDLE;
			done_q      <= 1'b0;
			emit_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (ph_q)
				P_IDLE: begin
					if (cmd.start) begin
						priority if (cmd.action == sled_pkg::ACT_BASE) begin
							base_q <= sig;
							done_q <= 1'b1; emit_q <= 1'b0;
						end else if (cmd.action == sled_pkg::ACT_EVENT) begin
							evt_q <= sig; evt_start_q <= now_ms;
							done_q <= 1'b1; emit_q <= 1'b0;
						end else if (cmd.action == sled_pkg::ACT_TICK) begin
							if (evt_q != 5'd0 && ev_pat.dur != 11'd0
								&& el <= {21'b0, ev_pat.dur}) begin
								pat_q <= ev_pat; t_q <= el;
							end else begin
								if (evt_q != 5'd0) evt_q <= '0;
								pat_q <= sled_pkg::pattern_of(base_q); t_q <= now_ms;
							end
							ph_q <= P_SEL;
						end else begin
							done_q <= 1'b1; emit_q <= 1'b0;
						end
					end
				end
				P_SEL: begin
					pal_q <= palc;
					unique case (pat_q.mode)
						sled_pkg::MODE_SOLID: begin next_q <= palc; ph_q <= P_FIN; end
						sled_pkg::MODE_OFF:   begin next_q <= '0; ph_q <= P_FIN; end
						default: begin
							dvd_q <= t_q; rem_q <= '0; dvs_q <= pat_q.period;
							dcnt_q <= 6'd32; ph_q <= P_MOD;
						end
					endcase
				end
				P_MOD: begin
					if (dcnt_q != 6'd0) begin
						dvd_q <= {dvd_q[30:0], ~rsub[13]};
						rem_q <= rsub[13] ? rtry[11:0] : rsub[11:0];
						dcnt_q <= dcnt_q - 6'd1;
					end else begin
						cyc_q <= rem_q;
						ph_q <= P_LVL;
					end
				end
				P_LVL: begin
					if (pat_q.mode == sled_pkg::MODE_BLINK) begin
						next_q <= blink_on ? pal_q : 24'd0;
						ph_q <= P_FIN;
					end else begin
						// (255-min)*ramp / half
						dvd_q <= {12'b0, lvl_num};
						rem_q <= '0; dvs_q <= half; dcnt_q <= 6'd32;
						ph_q <= P_LDIV;
					end
				end
				P_LDIV: begin
					if (dcnt_q != 6'd0) begin
						dvd_q <= {dvd_q[30:0], ~rsub[13]};
						rem_q <= rsub[13] ? rtry[11:0] : rsub[11:0];
						dcnt_q <= dcnt_q - 6'd1;
					end else begin
						lvl_q <= pat_q.minlvl + dvd_q[7:0];
						chan_q <= 2'd0;
						ph_q <= P_SCL;
					end
				end
				P_SCL: begin
					// one channel per cycle
					if (lvl_q == sled_pkg::FULL_LEVEL) begin
						next_q <= pal_q; ph_q <= P_FIN;
					end else begin
						unique case (chan_q)
							2'd0:    next_q[23:16] <= chq;
							2'd1:    next_q[15:8]  <= chq;
							default: next_q[7:0]   <= chq;
						endcase
						if (chan_q == 2'd2) ph_q <= P_FIN;
						else chan_q <= chan_q + 2'd1;
					end
				end
				P_FIN: begin
					emit_q <= (next_q != shown_q);
					shown_q <= next_q;
					done_q <= 1'b1;
					ph_q <= P_IDLE;
				end
				default: ph_q <= P_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/status_led_pattern_engine_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// RGB status LED pattern engine.
// Input channel (in_valid/in_ready): action, now_ms, signal. Action 1 sets
// the base signal, 2 starts an event at now_ms, 0 is a tick that computes
// the current colour; a tick returns one out transaction (red/green/blue)
// only when the colour differs from the last one shown.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0..5 picks a
// 48-bit palette register, two RGB colours; other indexes are dropped.
// Write config only while idle.
// One item at a time. A solid tick shows the palette colour, an off tick
// black; blink and breathe run a 32-step period modulo on a shared
// one-bit-per-cycle divider; breathe adds a 32-step level divide and scales
// the three channels one per cycle, or shows the palette colour if full.
// Reset: base signal 1, no event, shown colour black, palette zero.
// While out_ready is low the result is held and no new input is taken.
module status_led_pattern_engine_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] now_ms,
	input  wire logic [4:0]  signal,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_data
);

	sled_pkg::cmd_t cmd;
	sled_pkg::sts_t sts;
	logic [23:0]    color;

	assign cfg_ready = 1'b1;
	assign red   = color[23:16];
	assign green = color[15:8];
	assign blue  = color[7:0];

	sled_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);

	sled_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .now_ms(now_ms),
		.sig(signal), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .color(color)
	);

endmodule
`default_nettype wire

@@ rtl/sled_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sled_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] red,
	input wire logic [7:0] green,
	input wire logic [7:0] blue
);

	// one item in flight: no input taken while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready)) else $error("input ready with result pending");

	// a result follows a transaction, never directly after another result
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> !out_valid) else $error("result repeated");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable({red, green, blue})))
		else $error("result dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("second item accepted");

endmodule

bind status_led_pattern_engine_core sled_checker u_sled_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .red(red), .green(green),
	.blue(blue)
);
`default_nettype wire
